FILE: sv/nes_pkg.sv
// Shared types, codes and helpers of the note event scheduler.
package nes_pkg;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_FINISH = 3'd2,
    CMD_PLAY   = 3'd3,
    CMD_PAUSE  = 3'd4,
    CMD_STOP   = 3'd5,
    CMD_SEEK   = 3'd6,
    CMD_TICK   = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    K_POS     = 3'd0,
    K_ON      = 3'd1,
    K_OFF     = 3'd2,
    K_STARTED = 3'd3,
    K_PAUSED  = 3'd4,
    K_STOPPED = 3'd5,
    K_NOTLOAD = 3'd6,
    K_LOADED  = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    RD_IDX_M1,
    RD_IDX_P1,
    RD_NN,
    RD_NN_P1,
    RD_ZERO
  } rd_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_INS_RD,
    S_INS_CHK,
    S_SEEK_CHK,
    S_ON_CHK,
    S_OFF_CHK,
    S_EMIT_STOP,
    S_FLUSH
  } state_e;

  localparam int unsigned CFG_IDX_W   = 2;
  localparam logic [1:0]  CFG_TEMPO   = 2'd0;
  localparam logic [1:0]  CFG_TOTAL   = 2'd1;
  localparam logic [9:0]  TEMPO_RESET = 10'd120;
  localparam int unsigned STEP_W      = 9;

  typedef struct packed {
    logic [6:0]  pitch;
    logic [6:0]  velocity;
    logic [23:0] start;
    logic [23:0] length;
  } note_t;

  typedef struct packed {
    logic    accept;
    logic    clr_tab;
    logic    clr_loaded;
    logic    set_loaded;
    logic    set_play;
    logic    clr_play;
    logic    pos_clr;
    logic    pos_step;
    logic    pos_seek;
    logic    nn_clr;
    logic    nn_inc;
    logic    idx_from_cnt;
    logic    idx_clr;
    logic    idx_inc;
    logic    idx_dec;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    logic    wr_new;
    logic    cnt_inc;
    logic    emit;
    kind_e   ekind;
    logic    drop_set;
    logic    flush;
  } ctl_t;

  typedef struct packed {
    logic  in_fire;
    cmd_e  cmd;
    logic  loaded;
    logic  playing;
    logic  full;
    logic  cnt_zero;
    logic  idx_zero;
    logic  tick_stop;
    logic  nn_lt_cnt;
    logic  nn_more;
    logic  idx_more;
    logic  ins_gt;
    logic  seek_lt;
    logic  on_hit;
    logic  off_hit;
    logic  n_lt_max;
    logic  emit_ok;
    logic  out_free;
  } stat_t;

  // floor(50*tempo/120) = floor(5*tempo/12), reciprocal of 12 is 2731/2^15
  function automatic logic [STEP_W-1:0] step_of(input logic [9:0] tempo);
    logic [12:0] t5;
    logic [24:0] prod;
    t5   = 13'(tempo) * 13'd5;
    prod = 25'(t5) * 25'd2731;
    return prod[15 +: STEP_W];
  endfunction

endpackage

FILE: sv/nes_if.sv
// Valid/ready channel interfaces for commands and events.
interface nes_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic [6:0]         note_pitch;
  logic [6:0]         note_velocity;
  logic [23:0]        note_start_ms;
  logic [23:0]        note_length_ms;
  logic signed [24:0] seek_ms;

  modport source (output valid, command, note_pitch, note_velocity, note_start_ms,
                  note_length_ms, seek_ms, input ready);
  modport sink (input valid, command, note_pitch, note_velocity, note_start_ms,
                note_length_ms, seek_ms, output ready);
endinterface

interface nes_evt_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [23:0] position_ms;
  logic [6:0]  pitch;
  logic [6:0]  velocity;
  logic        dropped;
  logic        last;

  modport source (output valid, kind, position_ms, pitch, velocity, dropped, last,
                  input ready);
  modport sink (input valid, kind, position_ms, pitch, velocity, dropped, last,
                output ready);
endinterface

FILE: sv/nes_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nes_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0]   waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0]   raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

FILE: sv/nes_datapath.sv
// Datapath: note table, position, counters, pending event and output register.
module nes_datapath #(
  parameter int unsigned NOTE_DEPTH = 256,
  parameter int unsigned MAX_EVENTS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [nes_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [23:0]                    cfg_data_i,
  nes_cmd_if.sink                        cmd_i,
  nes_evt_if.source                      evt_o,
  input  nes_pkg::ctl_t                  ctl_i,
  output nes_pkg::stat_t                 stat_o
);
  localparam int unsigned CW = $clog2(NOTE_DEPTH + 1);
  localparam int unsigned AW = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;
  localparam int unsigned NW = $clog2(MAX_EVENTS + 1);

  nes_pkg::cmd_e      cmd_q;
  logic [6:0]         in_pitch_q, in_vel_q;
  logic [23:0]        in_start_q, in_len_q;
  logic signed [24:0] seek_q;

  logic [CW-1:0] count_q, nn_q, idx_q;
  logic [23:0]   pos_q, total_q;
  logic [nes_pkg::STEP_W-1:0] step_q;
  logic          playing_q, loaded_q, drop_q;
  logic [NW-1:0] n_q;

  logic          pend_v_q;
  nes_pkg::kind_e pend_kind_q;
  logic [6:0]    pend_pitch_q, pend_vel_q;

  logic          out_v_q, out_drop_q, out_last_q;
  logic [2:0]    out_kind_q;
  logic [23:0]   out_pos_q;
  logic [6:0]    out_pitch_q, out_vel_q;

  nes_pkg::note_t rd, wnote;
  logic [AW-1:0]  raddr;
  logic           in_fire, out_free, push_mid, push_fin;
  logic [24:0]    np, note_end;
  logic [25:0]    end_step;
  logic [23:0]    seek_p;
  logic [CW-1:0]  nn_p1, idx_p1, idx_m1;

  assign in_fire  = cmd_i.valid && ctl_i.accept;
  assign out_free = !out_v_q || evt_o.ready;
  assign push_mid = ctl_i.emit && pend_v_q;
  assign push_fin = ctl_i.flush;

  assign nn_p1  = nn_q + CW'(1);
  assign idx_p1 = idx_q + CW'(1);
  assign idx_m1 = idx_q - CW'(1);

  always_comb begin
    unique case (ctl_i.rd_sel)
      nes_pkg::RD_IDX_M1: raddr = idx_m1[AW-1:0];
      nes_pkg::RD_IDX_P1: raddr = idx_p1[AW-1:0];
      nes_pkg::RD_NN:     raddr = nn_q[AW-1:0];
      nes_pkg::RD_NN_P1:  raddr = nn_p1[AW-1:0];
      default:            raddr = '0;
    endcase
  end

  always_comb begin
    wnote.pitch    = in_pitch_q;
    wnote.velocity = in_vel_q;
    wnote.start    = in_start_q;
    wnote.length   = in_len_q;
  end

  nes_ram #(.WIDTH($bits(nes_pkg::note_t)), .DEPTH(NOTE_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.wr_en),
    .waddr_i (idx_q[AW-1:0]),
    .wdata_i (ctl_i.wr_new ? wnote : rd),
    .re_i    (ctl_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rd)
  );

  assign np       = 25'(pos_q) + 25'(step_q);
  assign note_end = 25'(rd.start) + 25'(rd.length);
  assign end_step = 26'(note_end) + 26'(step_q);
  assign seek_p   = seek_q[24] ? 24'd0 :
                    (seek_q[23:0] > total_q ? total_q : seek_q[23:0]);

  always_comb begin
    stat_o.in_fire   = in_fire;
    stat_o.cmd       = cmd_q;
    stat_o.loaded    = loaded_q;
    stat_o.playing   = playing_q;
    stat_o.full      = (count_q == CW'(NOTE_DEPTH));
    stat_o.cnt_zero  = (count_q == '0);
    stat_o.idx_zero  = (idx_q == '0);
    stat_o.tick_stop = (np >= 25'(total_q));
    stat_o.nn_lt_cnt = (nn_q < count_q);
    stat_o.nn_more   = (nn_p1 < count_q);
    stat_o.idx_more  = (idx_p1 < count_q);
    stat_o.ins_gt    = (rd.start > in_start_q);
    stat_o.seek_lt   = (rd.start < pos_q);
    stat_o.n_lt_max  = (n_q < NW'(MAX_EVENTS));
    stat_o.on_hit    = (rd.start <= pos_q) && (n_q < NW'(MAX_EVENTS));
    stat_o.off_hit   = (note_end <= 25'(pos_q)) && (end_step > 26'(pos_q));
    stat_o.emit_ok   = !pend_v_q || out_free;
    stat_o.out_free  = out_free;
  end

  // input latch and configuration
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q      <= nes_pkg::cmd_e'(cmd_i.command);
      in_pitch_q <= cmd_i.note_pitch;
      in_vel_q   <= cmd_i.note_velocity;
      in_start_q <= cmd_i.note_start_ms;
      in_len_q   <= cmd_i.note_length_ms;
      seek_q     <= cmd_i.seek_ms;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= nes_pkg::step_of(nes_pkg::TEMPO_RESET);
      total_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == nes_pkg::CFG_TEMPO) begin
        step_q <= nes_pkg::step_of(cfg_data_i[9:0]);
      end else if (cfg_idx_i == nes_pkg::CFG_TOTAL) begin
        total_q <= cfg_data_i;
      end
    end
  end

  // playback state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      nn_q      <= '0;
      idx_q     <= '0;
      pos_q     <= '0;
      playing_q <= 1'b0;
      loaded_q  <= 1'b0;
      drop_q    <= 1'b0;
      n_q       <= '0;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      if (ctl_i.clr_tab)    count_q <= '0;
      if (ctl_i.cnt_inc)    count_q <= count_q + CW'(1);
      if (ctl_i.nn_clr)     nn_q <= '0;
      if (ctl_i.nn_inc)     nn_q <= nn_p1;
      if (ctl_i.idx_from_cnt) idx_q <= count_q;
      if (ctl_i.idx_clr)    idx_q <= '0;
      if (ctl_i.idx_inc)    idx_q <= idx_p1;
      if (ctl_i.idx_dec)    idx_q <= idx_m1;
      if (ctl_i.pos_clr)    pos_q <= '0;
      if (ctl_i.pos_step)   pos_q <= np[23:0];
      if (ctl_i.pos_seek)   pos_q <= seek_p;
      if (ctl_i.set_play)   playing_q <= 1'b1;
      if (ctl_i.clr_play)   playing_q <= 1'b0;
      if (ctl_i.set_loaded) loaded_q <= 1'b1;
      if (ctl_i.clr_loaded) loaded_q <= 1'b0;
      if (in_fire) begin
        drop_q <= 1'b0;
        n_q    <= '0;
      end
      if (ctl_i.drop_set)   drop_q <= 1'b1;
      if (ctl_i.emit)       n_q <= n_q + NW'(1);
      if (ctl_i.emit) begin
        pend_v_q <= 1'b1;
      end else if (push_fin) begin
        pend_v_q <= 1'b0;
      end
      if (push_mid || push_fin) begin
        out_v_q <= 1'b1;
      end else if (evt_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // pending event and output payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      pend_kind_q  <= ctl_i.ekind;
      pend_pitch_q <= (ctl_i.ekind == nes_pkg::K_ON || ctl_i.ekind == nes_pkg::K_OFF)
                      ? rd.pitch : 7'd0;
      pend_vel_q   <= (ctl_i.ekind == nes_pkg::K_ON) ? rd.velocity : 7'd0;
    end
    if (push_mid || push_fin) begin
      out_kind_q  <= pend_kind_q;
      out_pos_q   <= pos_q;
      out_pitch_q <= pend_pitch_q;
      out_vel_q   <= pend_vel_q;
      out_last_q  <= push_fin;
      out_drop_q  <= push_fin && drop_q;
    end
  end

  assign cmd_i.ready       = ctl_i.accept;
  assign evt_o.valid       = out_v_q;
  assign evt_o.kind        = out_kind_q;
  assign evt_o.position_ms = out_pos_q;
  assign evt_o.pitch       = out_pitch_q;
  assign evt_o.velocity    = out_vel_q;
  assign evt_o.dropped     = out_drop_q;
  assign evt_o.last        = out_last_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !evt_o.ready) |-> !(push_mid || push_fin))
    else $error("output beat overwritten while stalled");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(NOTE_DEPTH))
    else $error("note count beyond table depth");
  a_nn_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nn_q <= count_q)
    else $error("note index beyond note count");
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NW'(MAX_EVENTS))
    else $error("event cap exceeded");
endmodule

FILE: sv/nes_ctrl.sv
// Controller state machine sequencing commands over the datapath.
module nes_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  nes_pkg::stat_t stat_i,
  output nes_pkg::ctl_t  ctl_o
);
  nes_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nes_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    ctl_o   = '0;
    ctl_o.rd_sel = nes_pkg::RD_ZERO;
    ctl_o.ekind  = nes_pkg::K_POS;
    state_d = state_q;
    unique case (state_q)
      nes_pkg::S_IDLE: begin
        ctl_o.accept = 1'b1;
        if (stat_i.in_fire) state_d = nes_pkg::S_DISP;
      end
      nes_pkg::S_DISP: begin
        unique case (stat_i.cmd)
          nes_pkg::CMD_CLEAR: begin
            ctl_o.clr_tab    = 1'b1;
            ctl_o.nn_clr     = 1'b1;
            ctl_o.pos_clr    = 1'b1;
            ctl_o.clr_play   = 1'b1;
            ctl_o.clr_loaded = 1'b1;
            state_d = nes_pkg::S_IDLE;
          end
          nes_pkg::CMD_APPEND: begin
            if (stat_i.loaded || stat_i.full) begin
              state_d = nes_pkg::S_IDLE;
            end else begin
              ctl_o.idx_from_cnt = 1'b1;
              state_d = nes_pkg::S_INS_RD;
            end
          end
          nes_pkg::CMD_FINISH: begin
            ctl_o.set_loaded = 1'b1;
            ctl_o.pos_clr    = 1'b1;
            ctl_o.nn_clr     = 1'b1;
            ctl_o.emit       = 1'b1;
            ctl_o.ekind      = nes_pkg::K_LOADED;
            state_d = nes_pkg::S_FLUSH;
          end
          nes_pkg::CMD_PLAY: begin
            ctl_o.emit     = 1'b1;
            ctl_o.set_play = stat_i.loaded;
            ctl_o.ekind    = stat_i.loaded ? nes_pkg::K_STARTED : nes_pkg::K_NOTLOAD;
            state_d = nes_pkg::S_FLUSH;
          end
          nes_pkg::CMD_PAUSE: begin
            ctl_o.clr_play = 1'b1;
            ctl_o.emit     = 1'b1;
            ctl_o.ekind    = nes_pkg::K_PAUSED;
            state_d = nes_pkg::S_FLUSH;
          end
          nes_pkg::CMD_STOP: begin
            ctl_o.clr_play = 1'b1;
            ctl_o.pos_clr  = 1'b1;
            ctl_o.nn_clr   = 1'b1;
            ctl_o.emit     = 1'b1;
            state_d = nes_pkg::S_EMIT_STOP;
          end
          nes_pkg::CMD_SEEK: begin
            if (!stat_i.loaded) begin
              state_d = nes_pkg::S_IDLE;
            end else begin
              ctl_o.pos_seek = 1'b1;
              ctl_o.nn_clr   = 1'b1;
              if (stat_i.cnt_zero) begin
                ctl_o.emit = 1'b1;
                state_d = nes_pkg::S_FLUSH;
              end else begin
                ctl_o.rd_en = 1'b1;
                state_d = nes_pkg::S_SEEK_CHK;
              end
            end
          end
          default: begin
            if (!stat_i.playing || !stat_i.loaded) begin
              state_d = nes_pkg::S_IDLE;
            end else if (stat_i.tick_stop) begin
              ctl_o.clr_play = 1'b1;
              ctl_o.pos_clr  = 1'b1;
              ctl_o.nn_clr   = 1'b1;
              ctl_o.emit     = 1'b1;
              state_d = nes_pkg::S_EMIT_STOP;
            end else begin
              ctl_o.pos_step = 1'b1;
              ctl_o.emit     = 1'b1;
              if (stat_i.nn_lt_cnt) begin
                ctl_o.rd_en  = 1'b1;
                ctl_o.rd_sel = nes_pkg::RD_NN;
                state_d = nes_pkg::S_ON_CHK;
              end else if (stat_i.cnt_zero) begin
                state_d = nes_pkg::S_FLUSH;
              end else begin
                ctl_o.rd_en   = 1'b1;
                ctl_o.idx_clr = 1'b1;
                state_d = nes_pkg::S_OFF_CHK;
              end
            end
          end
        endcase
      end
      nes_pkg::S_INS_RD: begin
        if (stat_i.idx_zero) begin
          ctl_o.wr_en   = 1'b1;
          ctl_o.wr_new  = 1'b1;
          ctl_o.cnt_inc = 1'b1;
          state_d = nes_pkg::S_IDLE;
        end else begin
          ctl_o.rd_en  = 1'b1;
          ctl_o.rd_sel = nes_pkg::RD_IDX_M1;
          state_d = nes_pkg::S_INS_CHK;
        end
      end
      nes_pkg::S_INS_CHK: begin
        ctl_o.wr_en = 1'b1;
        if (stat_i.ins_gt) begin
          ctl_o.idx_dec = 1'b1;
          state_d = nes_pkg::S_INS_RD;
        end else begin
          ctl_o.wr_new  = 1'b1;
          ctl_o.cnt_inc = 1'b1;
          state_d = nes_pkg::S_IDLE;
        end
      end
      nes_pkg::S_SEEK_CHK: begin
        if (stat_i.seek_lt && stat_i.nn_more) begin
          ctl_o.nn_inc = 1'b1;
          ctl_o.rd_en  = 1'b1;
          ctl_o.rd_sel = nes_pkg::RD_NN_P1;
        end else begin
          ctl_o.nn_inc = stat_i.seek_lt;
          ctl_o.emit   = 1'b1;
          state_d = nes_pkg::S_FLUSH;
        end
      end
      nes_pkg::S_ON_CHK: begin
        if (stat_i.on_hit) begin
          if (stat_i.emit_ok) begin
            ctl_o.emit   = 1'b1;
            ctl_o.ekind  = nes_pkg::K_ON;
            ctl_o.nn_inc = 1'b1;
            ctl_o.rd_en  = 1'b1;
            if (stat_i.nn_more) begin
              ctl_o.rd_sel = nes_pkg::RD_NN_P1;
            end else begin
              ctl_o.idx_clr = 1'b1;
              state_d = nes_pkg::S_OFF_CHK;
            end
          end
        end else begin
          ctl_o.rd_en   = 1'b1;
          ctl_o.idx_clr = 1'b1;
          state_d = nes_pkg::S_OFF_CHK;
        end
      end
      nes_pkg::S_OFF_CHK: begin
        if (!(stat_i.off_hit && stat_i.n_lt_max && !stat_i.emit_ok)) begin
          if (stat_i.off_hit) begin
            ctl_o.emit     = stat_i.n_lt_max;
            ctl_o.ekind    = nes_pkg::K_OFF;
            ctl_o.drop_set = !stat_i.n_lt_max;
          end
          ctl_o.idx_inc = 1'b1;
          if (stat_i.idx_more) begin
            ctl_o.rd_en  = 1'b1;
            ctl_o.rd_sel = nes_pkg::RD_IDX_P1;
          end else begin
            state_d = nes_pkg::S_FLUSH;
          end
        end
      end
      nes_pkg::S_EMIT_STOP: begin
        if (stat_i.emit_ok) begin
          ctl_o.emit  = 1'b1;
          ctl_o.ekind = nes_pkg::K_STOPPED;
          state_d = nes_pkg::S_FLUSH;
        end
      end
      nes_pkg::S_FLUSH: begin
        if (stat_i.out_free) begin
          ctl_o.flush = 1'b1;
          state_d = nes_pkg::S_IDLE;
        end
      end
      default: state_d = nes_pkg::S_IDLE;
    endcase
  end
endmodule

FILE: sv/note_event_scheduler_core.sv
// Top level of the note event scheduler: controller, datapath and note table.
//
// Usage: commands arrive as beats on cmd_i (clear, append, finish, play,
// pause, stop, seek, tick); result events leave as beats on evt_o, the
// final beat of a command flagged by last. tempo_bpm and total_duration_ms
// are written through cfg_we_i/cfg_idx_i/cfg_data_i while idle.
// One command is handled at a time; cmd_i.ready is high only when idle.
// Per command: an append moves entries up one place at a time to keep
// the table sorted by start, a seek steps past the notes that start
// before the new position, and a tick emits its note-ons, then scans
// the whole table for note-offs, one table entry a cycle through the
// single registered read port of the note RAM, pausing while the
// receiver stalls.
// Each event of a command sits in a holding stage until the next is
// known, so last can be set; an output register parts it from evt_o.
// When the receiver stalls the scan pauses and no beat is lost.
// Reset clears counters, position, flags and the channels; the note
// table itself is not cleared, entries beyond the count are never read.
module note_event_scheduler_core #(
  parameter int unsigned NOTE_DEPTH = 256,
  parameter int unsigned MAX_EVENTS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [nes_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [23:0]                   cfg_data_i,
  nes_cmd_if.sink                       cmd_i,
  nes_evt_if.source                     evt_o
);
  nes_pkg::ctl_t  ctl;
  nes_pkg::stat_t stat;

  // sequencing of each command
  nes_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  // table, position, event holding and output register
  nes_datapath #(
    .NOTE_DEPTH (NOTE_DEPTH),
    .MAX_EVENTS (MAX_EVENTS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd_i),
    .evt_o      (evt_o),
    .ctl_i      (ctl),
    .stat_o     (stat)
  );
endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the note event scheduler core.
module tb;

  localparam int TABLE_DEPTH = 256;
  localparam int EVENT_CAP   = 64;
  localparam int WDOG_LIMIT  = 20000;
  localparam int DRAIN_WAIT  = 600;   // lets the worst append shuffle, which emits no event, finish

  typedef struct {
    nes_pkg::cmd_e      cmd;
    logic [6:0]         pitch;
    logic [6:0]         vel;
    logic [23:0]        start;
    logic [23:0]        len;
    logic signed [24:0] seek;
  } cmd_item_t;

  typedef struct {
    nes_pkg::kind_e kind;
    logic [23:0]    pos;
    logic [6:0]     pitch;
    logic [6:0]     vel;
    logic           dropped;
    logic           last;
  } evt_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [23:0] cfg_data;

  nes_cmd_if cmd_if ();
  nes_evt_if evt_if ();

  note_event_scheduler_core u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .cmd_i     (cmd_if),
    .evt_o     (evt_if)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Shadow of the scheduler state, kept in step with accepted commands
  // ---------------------------------------------------------------------
  nes_pkg::note_t song_tbl [TABLE_DEPTH];
  int unsigned song_len;
  int unsigned cursor;
  logic [23:0] play_pos;
  bit          running;
  bit          song_loaded;
  logic [9:0]  tempo_shadow;
  logic [23:0] total_shadow;

  cmd_item_t pending_cmds [$];
  evt_item_t due_events   [$];
  cmd_item_t cur_cmd;

  int send_idle_pct;
  int recv_stall_pct;
  int mismatches;
  bit hold_req;

  function automatic void push_evt(ref evt_item_t batch [$], input nes_pkg::kind_e k,
                                   input logic [6:0] p, input logic [6:0] v);
    evt_item_t e;
    e.kind = k; e.pos = play_pos; e.pitch = p; e.vel = v;
    e.dropped = 1'b0; e.last = 1'b0;
    batch.push_back(e);
  endfunction

  function automatic void stop_song(ref evt_item_t batch [$]);
    running  = 1'b0;
    play_pos = '0;
    cursor   = 0;
    push_evt(batch, nes_pkg::K_POS, 7'd0, 7'd0);
    push_evt(batch, nes_pkg::K_STOPPED, 7'd0, 7'd0);
  endfunction

  // Works out the events an accepted command must produce and queues them.
  function automatic void predict_events(input cmd_item_t c);
    evt_item_t   batch [$];
    bit          lost_off;
    int unsigned step, np, idx, ends;
    lost_off = 1'b0;
    case (c.cmd)
      nes_pkg::CMD_CLEAR: begin
        song_len = 0; cursor = 0; play_pos = '0;
        running = 1'b0; song_loaded = 1'b0;
      end
      nes_pkg::CMD_APPEND: begin
        if (!song_loaded && song_len < TABLE_DEPTH) begin
          idx = song_len;
          while (idx > 0 && song_tbl[idx-1].start > c.start) begin
            song_tbl[idx] = song_tbl[idx-1];
            idx--;
          end
          song_tbl[idx] = '{pitch: c.pitch, velocity: c.vel, start: c.start, length: c.len};
          song_len++;
        end
      end
      nes_pkg::CMD_FINISH: begin
        song_loaded = 1'b1; play_pos = '0; cursor = 0;
        push_evt(batch, nes_pkg::K_LOADED, 7'd0, 7'd0);
      end
      nes_pkg::CMD_PLAY: begin
        if (song_loaded) begin
          running = 1'b1;
          push_evt(batch, nes_pkg::K_STARTED, 7'd0, 7'd0);
        end else begin
          push_evt(batch, nes_pkg::K_NOTLOAD, 7'd0, 7'd0);
        end
      end
      nes_pkg::CMD_PAUSE: begin
        running = 1'b0;
        push_evt(batch, nes_pkg::K_PAUSED, 7'd0, 7'd0);
      end
      nes_pkg::CMD_STOP: stop_song(batch);
      nes_pkg::CMD_SEEK: begin
        if (song_loaded) begin
          if (c.seek[24])                         play_pos = '0;
          else if (c.seek[23:0] > total_shadow)   play_pos = total_shadow;
          else                                    play_pos = c.seek[23:0];
          cursor = 0;
          while (cursor < song_len && song_tbl[cursor].start < play_pos) cursor++;
          push_evt(batch, nes_pkg::K_POS, 7'd0, 7'd0);
        end
      end
      default: begin  // tick
        if (running && song_loaded) begin
          step = (50 * tempo_shadow) / 120;
          np   = play_pos + step;
          if (np >= total_shadow) begin
            stop_song(batch);
          end else begin
            play_pos = np[23:0];
            push_evt(batch, nes_pkg::K_POS, 7'd0, 7'd0);
            // note-ons beyond the cap stay pending for the next tick
            while (cursor < song_len && batch.size() < EVENT_CAP &&
                   song_tbl[cursor].start <= play_pos) begin
              push_evt(batch, nes_pkg::K_ON, song_tbl[cursor].pitch,
                       song_tbl[cursor].velocity);
              cursor++;
            end
            // note-offs beyond the cap are lost, flagged on the final beat
            for (int unsigned i = 0; i < song_len; i++) begin
              ends = song_tbl[i].start + song_tbl[i].length;
              if (ends <= play_pos && ends + step > play_pos) begin
                if (batch.size() < EVENT_CAP)
                  push_evt(batch, nes_pkg::K_OFF, song_tbl[i].pitch, 7'd0);
                else lost_off = 1'b1;
              end
            end
          end
        end
      end
    endcase
    if (batch.size() > 0) begin
      batch[$].last    = 1'b1;
      batch[$].dropped = lost_off;
    end
    foreach (batch[i]) due_events.push_back(batch[i]);
  endfunction

  // ---------------------------------------------------------------------
  // Command driver: presents queued commands, predicts on each accepted beat
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) predict_events(cur_cmd);
      if (!cmd_if.valid || cmd_if.ready) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_cmd = pending_cmds.pop_front();
          cmd_if.valid          <= 1'b1;
          cmd_if.command        <= cur_cmd.cmd;
          cmd_if.note_pitch     <= cur_cmd.pitch;
          cmd_if.note_velocity  <= cur_cmd.vel;
          cmd_if.note_start_ms  <= cur_cmd.start;
          cmd_if.note_length_ms <= cur_cmd.len;
          cmd_if.seek_ms        <= cur_cmd.seek;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Event monitor: random back-pressure, one long hold-off on request
  // ---------------------------------------------------------------------
  int  hold_left;
  bit  hold_used;

  always @(posedge clk_i) begin
    evt_item_t want;
    if (!rst_ni) begin
      evt_if.ready <= 1'b0;
      hold_left    <= 0;
      hold_used    <= 1'b0;
    end else begin
      if (evt_if.valid && evt_if.ready) begin
        if (due_events.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected event beat: kind %0d pos %0d pitch %0d",
                     evt_if.kind, evt_if.position_ms, evt_if.pitch);
          mismatches++;
        end else begin
          want = due_events.pop_front();
          if (evt_if.kind !== want.kind || evt_if.position_ms !== want.pos ||
              evt_if.pitch !== want.pitch || evt_if.velocity !== want.vel ||
              evt_if.dropped !== want.dropped || evt_if.last !== want.last) begin
            if (mismatches < 10)
              $display("event mismatch: exp k%0d p%0d n%0d v%0d d%0d l%0d / got k%0d p%0d n%0d v%0d d%0d l%0d",
                       want.kind, want.pos, want.pitch, want.vel, want.dropped, want.last,
                       evt_if.kind, evt_if.position_ms, evt_if.pitch, evt_if.velocity,
                       evt_if.dropped, evt_if.last);
            mismatches++;
          end
        end
      end
      if (hold_req && !hold_used) begin
        hold_used    <= 1'b1;
        hold_left    <= 1500;
        evt_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        evt_if.ready <= 1'b0;
      end else begin
        evt_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog on cycles with no beat on either channel
  int quiet_cycles;
  always @(posedge clk_i) begin
    if (!rst_ni || (cmd_if.valid && cmd_if.ready) || (evt_if.valid && evt_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------
  function automatic cmd_item_t rand_cmd(input nes_pkg::cmd_e c);
    cmd_item_t it;
    it.cmd   = c;
    it.pitch = 7'($urandom());
    it.vel   = 7'($urandom());
    it.start = 24'($urandom());
    it.len   = 24'($urandom());
    it.seek  = 25'($urandom());
    return it;
  endfunction

  task automatic add_cmd(input nes_pkg::cmd_e c);
    pending_cmds.push_back(rand_cmd(c));
  endtask

  task automatic add_note(input int unsigned st, input int unsigned ln);
    cmd_item_t it;
    it = rand_cmd(nes_pkg::CMD_APPEND);
    it.start = st[23:0];
    it.len   = ln[23:0];
    pending_cmds.push_back(it);
  endtask

  task automatic add_seek(input int sk);
    cmd_item_t it;
    it = rand_cmd(nes_pkg::CMD_SEEK);
    it.seek = 25'(sk);
    pending_cmds.push_back(it);
  endtask

  // One well-formed song load followed by a playback session with some noise.
  task automatic add_song(input int nnotes, input int span, input int nops);
    int r;
    add_cmd(nes_pkg::CMD_CLEAR);
    for (int i = 0; i < nnotes; i++) begin
      if ($urandom_range(19) == 0) add_note($urandom(), $urandom());
      else add_note($urandom_range(span), $urandom_range(span / 3));
    end
    add_cmd(nes_pkg::CMD_FINISH);
    add_cmd(nes_pkg::CMD_PLAY);
    for (int i = 0; i < nops; i++) begin
      r = $urandom_range(99);
      if (r < 68)      add_cmd(nes_pkg::CMD_TICK);
      else if (r < 74) add_seek($urandom_range(span + 200) - 100);
      else if (r < 76) add_seek(int'($urandom()));
      else if (r < 80) add_cmd(nes_pkg::CMD_PAUSE);
      else if (r < 87) add_cmd(nes_pkg::CMD_PLAY);
      else if (r < 90) add_cmd(nes_pkg::CMD_STOP);
      else             add_cmd(nes_pkg::cmd_e'($urandom_range(7)));
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic set_regs(input logic [9:0] tempo, input logic [23:0] total);
    write_reg(nes_pkg::CFG_TEMPO, 24'(tempo));
    write_reg(nes_pkg::CFG_TOTAL, total);
    tempo_shadow = tempo;
    total_shadow = total;
  endtask

  // Waits for every command to go and every event to come back, then lets
  // any silent table shuffle finish before the next register write.
  task automatic drain;
    do @(posedge clk_i);
    while (pending_cmds.size() > 0 || cmd_if.valid || due_events.size() > 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  initial begin
    cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
    cmd_if.valid = 1'b0; cmd_if.command = '0; cmd_if.note_pitch = '0;
    cmd_if.note_velocity = '0; cmd_if.note_start_ms = '0;
    cmd_if.note_length_ms = '0; cmd_if.seek_ms = '0;
    evt_if.ready = 1'b0;
    send_idle_pct = 0; recv_stall_pct = 0; mismatches = 0; hold_req = 1'b0;
    song_len = 0; cursor = 0; play_pos = '0; running = 1'b0; song_loaded = 1'b0;
    tempo_shadow = nes_pkg::TEMPO_RESET; total_shadow = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: unloaded cases, field extremes, ignored appends, seek clamps
    set_regs(10'd120, 24'd3000);
    add_cmd(nes_pkg::CMD_CLEAR);
    add_cmd(nes_pkg::CMD_TICK);           // not playing: nothing
    add_cmd(nes_pkg::CMD_PLAY);           // before load: not loaded
    add_seek(500);                        // not loaded: ignored
    add_note(24'hFFFFFF, 24'hFFFFFF);
    add_note(0, 0);
    add_note(60, 40);
    add_note(60, 100);
    add_cmd(nes_pkg::CMD_FINISH);
    add_note(10, 10);                     // loaded: ignored
    add_cmd(nes_pkg::CMD_PLAY);
    add_cmd(nes_pkg::CMD_TICK);
    add_cmd(nes_pkg::CMD_TICK);
    add_seek(-16777216);                  // clamps to zero
    add_seek(16777215);                   // clamps to the total
    add_seek(55);
    add_cmd(nes_pkg::CMD_TICK);
    add_cmd(nes_pkg::CMD_PAUSE);
    add_cmd(nes_pkg::CMD_TICK);           // paused: nothing
    add_cmd(nes_pkg::CMD_PLAY);
    add_cmd(nes_pkg::CMD_STOP);
    add_seek(2990);
    add_cmd(nes_pkg::CMD_PLAY);
    add_cmd(nes_pkg::CMD_TICK);           // reaches the end: stops
    drain();

    // Random phases across idling modes and register settings
    add_song(5, 2000, 12);
    drain();

    send_idle_pct = 82;
    set_regs(10'd1023, 24'hFFFFFF);
    add_song(5, 12000, 10);
    drain();

    send_idle_pct = 0; recv_stall_pct = 82;
    set_regs(10'd1, 24'd0);               // zero step, stops on every tick
    add_song(3, 200, 6);
    drain();

    set_regs(10'd300, 24'd6000);
    hold_req = 1'b1;                      // long receiver hold-off
    add_song(5, 5000, 10);
    drain();

    send_idle_pct = 27; recv_stall_pct = 27;
    set_regs(10'd57, 24'd4000);
    add_song(5, 3500, 10);
    drain();

    // Full table, densely packed: extra appends are ignored, ticks scan every
    // entry, hit the event cap, hold note-ons back and drop note-offs
    set_regs(10'd1023, 24'hFFFFFF);
    add_cmd(nes_pkg::CMD_CLEAR);
    for (int i = 0; i < TABLE_DEPTH + 2; i++) add_note(i * 2, $urandom_range(300));
    add_cmd(nes_pkg::CMD_FINISH);
    add_cmd(nes_pkg::CMD_PLAY);
    repeat (8) add_cmd(nes_pkg::CMD_TICK);
    drain();

    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
